/* rtl/cbp_pkg.sv */
package cbp_pkg;

  // Sizing defaults
  localparam int MAX_ADDR_BITS = 10;
  localparam int MAX_HIST_BITS = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int ADDR_BITS_W = 4;
  localparam int HIST_BITS_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ADDR_BITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_BITS = 1'd1;

  localparam logic [ADDR_BITS_W-1:0] ADDR_BITS_RST = 4'd10;
  localparam logic [HIST_BITS_W-1:0] HIST_BITS_RST = 3'd2;

  // Stream widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  // Two-bit counter codes
  localparam logic [1:0] CNT_STRONG_NT = 2'd0;
  localparam logic [1:0] CNT_WEAK_NT   = 2'd1;
  localparam logic [1:0] CNT_WEAK_T    = 2'd2;
  localparam logic [1:0] CNT_STRONG_T  = 2'd3;

  // Hysteresis update: a weak counter jumps straight to the strong state
  function automatic logic [1:0] cnt_next(input logic [1:0] cnt, input logic taken);
    logic [1:0] res;
    if (taken) begin
      res = (cnt == CNT_STRONG_NT) ? CNT_WEAK_NT : CNT_STRONG_T;
    end else begin
      res = (cnt == CNT_STRONG_T) ? CNT_WEAK_T : CNT_STRONG_NT;
    end
    return res;
  endfunction

endpackage

/* rtl/cbp_ctrl.sv */
module cbp_ctrl #(
  parameter int MaxAddrBits = cbp_pkg::MAX_ADDR_BITS,
  parameter int MaxHistBits = cbp_pkg::MAX_HIST_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           accept,
  input  logic [31:0]                    branch_address,
  input  logic                           taken,
  output logic [MaxAddrBits-1:0]         row,
  output logic [MaxHistBits-1:0]         col
);
  import cbp_pkg::*;

  logic [ADDR_BITS_W-1:0] addr_bits;
  logic [HIST_BITS_W-1:0] history_bits;
  logic [MaxHistBits-1:0] ghist;
  logic [MaxHistBits-1:0] ghist_next;
  logic                   hist_used;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_bits    <= ADDR_BITS_RST;
      history_bits <= HIST_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ADDR_BITS: addr_bits    <= cfg_data[ADDR_BITS_W-1:0];
        REG_HIST_BITS: history_bits <= cfg_data[HIST_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Mask the address row; widths beyond the table saturate by construction
  always_comb begin
    for (int i = 0; i < MaxAddrBits; i++) begin
      row[i] = branch_address[i] & (i < int'(addr_bits));
    end
  end

  // Mask the history column and form the shifted history
  always_comb begin
    int k;
    k = (int'(history_bits) > MaxHistBits) ? MaxHistBits : int'(history_bits);
    hist_used = (k != 0);
    for (int i = 0; i < MaxHistBits; i++) begin
      col[i] = ghist[i] & (i < k);
      if (i + 1 < k) begin
        ghist_next[i] = ghist[(i + 1) % MaxHistBits];
      end else if (i + 1 == k) begin
        ghist_next[i] = taken;
      end else begin
        ghist_next[i] = 1'b0;
      end
    end
  end

  // Advance the global history on every accepted transaction when the history length is nonzero
  always_ff @(posedge clk) begin
    if (rst) begin
      ghist <= '1;
    end else if (accept && hist_used) begin
      ghist <= ghist_next;
    end
  end

endmodule

/* rtl/cbp_table.sv */
module cbp_table #(
  parameter int MaxAddrBits = cbp_pkg::MAX_ADDR_BITS,
  parameter int MaxHistBits = cbp_pkg::MAX_HIST_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [MaxAddrBits-1:0]          rd_row,
  output logic [2*(2**MaxHistBits)-1:0]   rd_data,
  input  logic                            wr_en,
  input  logic [MaxAddrBits-1:0]          wr_row,
  input  logic [2*(2**MaxHistBits)-1:0]   wr_data,
  output logic                            busy
);
  import cbp_pkg::*;

  localparam int Rows = 2**MaxAddrBits;
  localparam int RowW = 2*(2**MaxHistBits);

  logic [RowW-1:0]        mem [Rows];
  logic [MaxAddrBits-1:0] clr_row;
  logic                   mem_we;
  logic [MaxAddrBits-1:0] mem_waddr;
  logic [RowW-1:0]        mem_wdata;

  // Sweep every row to strongly taken after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + 1'b1;
      if (&clr_row) begin
        busy <= 1'b0;
      end
    end
  end

  // Select clearing writes over update writes
  always_comb begin
    mem_we    = busy | wr_en;
    mem_waddr = busy ? clr_row : wr_row;
    mem_wdata = busy ? {(2**MaxHistBits){CNT_STRONG_T}} : wr_data;
  end

  // Row memory, read-first, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

/* rtl/correlating_branch_predictor.sv */
// Correlating (m,k) branch predictor with two-bit hysteresis counters.
//
// Input stream (s_*): one transaction per resolved branch, carrying the
// branch address and its actual outcome. Output stream (m_*): one
// transaction per input, carrying the prediction read before the update
// and a mispredict flag, in input order.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 = address bits m, 1 = history bits k); write only while idle.
//
// An accepted input passes through the synchronous read of the counter
// row and then the output register before it appears as output valid.
// Throughput is one transaction per cycle when the output is not stalled;
// the counter memory has one read and one write port, and a back-to-back
// update of the same row is forwarded from the previous write.
// A stalled output holds its transaction; the read stage behind it holds
// too, and s_tready drops only when both are full and m_tready is low, or
// during the sweep: after reset the counter memory is swept to strongly
// taken, one row per cycle, over all 2**MaxAddrBits rows (1024 by default).
// The global history resets to all ones.
module correlating_branch_predictor #(
  parameter int MaxAddrBits = cbp_pkg::MAX_ADDR_BITS,
  parameter int MaxHistBits = cbp_pkg::MAX_HIST_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [cbp_pkg::IN_DATA_W-1:0]  s_tdata,  // branch_address[31:0], taken[32]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cbp_pkg::OUT_DATA_W-1:0] m_tdata,  // prediction[0], mispredict[1]
  input  logic                           cfg_we,
  input  logic [cbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cbp_pkg::*;

  localparam int RowW = 2*(2**MaxHistBits);

  logic                   accept;
  logic                   busy;
  logic [MaxAddrBits-1:0] in_row;
  logic [MaxHistBits-1:0] in_col;
  logic [RowW-1:0]        rd_data;

  logic                   s1_valid;
  logic                   s1_move;
  logic [MaxAddrBits-1:0] s1_row;
  logic [MaxHistBits-1:0] s1_col;
  logic                   s1_taken;
  logic                   s1_fwd;
  logic [RowW-1:0]        s1_fwd_data;
  logic [RowW-1:0]        s1_cur;
  logic [RowW-1:0]        s1_new;
  logic [1:0]             s1_cnt;
  logic                   s1_pred;

  logic                   out_valid;
  logic                   out_pred;
  logic                   out_mis;

  // Handshake: the read stage advances when the output register is free
  assign s1_move  = s1_valid & (~out_valid | m_tready);
  assign s_tready = ~busy & (~s1_valid | s1_move);
  assign accept   = s_tvalid & s_tready;

  cbp_ctrl #(
    .MaxAddrBits(MaxAddrBits),
    .MaxHistBits(MaxHistBits)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .branch_address(s_tdata[31:0]),
    .taken         (s_tdata[32]),
    .row           (in_row),
    .col           (in_col)
  );

  cbp_table #(
    .MaxAddrBits(MaxAddrBits),
    .MaxHistBits(MaxHistBits)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_row (in_row),
    .rd_data(rd_data),
    .wr_en  (s1_move),
    .wr_row (s1_row),
    .wr_data(s1_new),
    .busy   (busy)
  );

  // Read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the transaction; flag a row written at the same edge as the read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row      <= in_row;
      s1_col      <= in_col;
      s1_taken    <= s_tdata[32];
      s1_fwd      <= s1_move && (s1_row == in_row);
      s1_fwd_data <= s1_new;
    end
  end

  // Modify the counter within its row
  always_comb begin
    s1_cur  = s1_fwd ? s1_fwd_data : rd_data;
    s1_cnt  = s1_cur[2*s1_col +: 2];
    s1_pred = (s1_cnt == CNT_WEAK_T) || (s1_cnt == CNT_STRONG_T);
    s1_new  = s1_cur;
    s1_new[2*s1_col +: 2] = cnt_next(s1_cnt, s1_taken);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_pred <= s1_pred;
      out_mis  <= s1_pred ^ s1_taken;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_mis, out_pred};

  // No transaction enters while the memory is being cleared
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !accept)
    else $error("transaction accepted during clearing pass");

  // A held read stage keeps its row data
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> $stable(rd_data))
    else $error("read data lost while stage stalled");

  // Every advance of the read stage shows up at the output
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> m_tvalid)
    else $error("advanced transaction missing at output");

endmodule
